// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define BGFP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked at every rising clock edge, reset included.
`define BGFP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/bgfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgfp_pkg: shared types and constants of the binary frame parser
// Holds the parser phase type, the result item layout, register indexes
// and the sizing of the queue between the front and the back.
// ----------------------------------------------------------------------------
package bgfp_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;

	// Reset values of the preamble registers.
	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd69;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd82;

	// Result kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	// Parser phases.
	typedef enum logic [7:0] {
		PH_HUNT    = 8'b0000_0001,
		PH_SYNC2   = 8'b0000_0010,
		PH_ID      = 8'b0000_0100,
		PH_LEN_LO  = 8'b0000_1000,
		PH_LEN_HI  = 8'b0001_0000,
		PH_PAYLOAD = 8'b0010_0000,
		PH_SUM_A   = 8'b0100_0000,
		PH_SUM_B   = 8'b1000_0000
	} phase_t;

	// One result item.
	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] id;
		logic [BYTE_W-1:0] pbyte;
		logic [LEN_W-1:0]  index;
		logic [LEN_W-1:0]  length;
		logic              ok_a;
		logic              ok_b;
		logic              good;
	} result_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ----- design/bgfp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgfp_front: byte acceptance and frame parsing
// Accepts one byte per cycle while the queue has room, tracks the frame phase
// and both running sums, and queues payload and end-of-frame items.
// ----------------------------------------------------------------------------
module bgfp_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [bgfp_pkg::BYTE_W-1:0]    rx_byte,
	input  wire logic                           cfg_we,
	input  wire logic [bgfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bgfp_pkg::BYTE_W-1:0]    cfg_data,
	input  wire bgfp_pkg::q_status_t            q_stat,
	output logic                                push,
	output bgfp_pkg::result_t                   push_data
);
	import bgfp_pkg::*;

	logic [BYTE_W-1:0] sync_first_q;
	logic [BYTE_W-1:0] sync_second_q;
	phase_t            phase_q;
	phase_t            phase_d;
	logic [BYTE_W-1:0] held_id_q;
	logic [BYTE_W-1:0] sum_a_q;
	logic [BYTE_W-1:0] sum_b_q;
	logic [LEN_W-1:0]  exp_len_q;
	logic [LEN_W-1:0]  rcv_cnt_q;
	logic              first_match_q;
	logic              accept;
	logic [BYTE_W-1:0] sum_a_next;
	logic [BYTE_W-1:0] sum_b_next;
	logic [LEN_W-1:0]  full_len;
	logic [LEN_W-1:0]  cnt_next;
	logic              ok_b;

	// The queue has room whenever a new byte may arrive.
	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	// Fletcher style running sums and header helpers.
	assign sum_a_next = sum_a_q + rx_byte;
	assign sum_b_next = sum_b_q + sum_a_next;
	assign full_len   = {rx_byte, exp_len_q[BYTE_W-1:0]};
	assign cnt_next   = rcv_cnt_q + LEN_W'(1);
	assign ok_b       = (sum_b_q == rx_byte);

	// Next phase and result item for the byte on the input.
	always_comb begin
		phase_d   = phase_q;
		push      = 1'b0;
		push_data = '0;
		push_data.id     = held_id_q;
		push_data.length = exp_len_q;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == sync_first_q) phase_d = PH_SYNC2;
			end
			PH_SYNC2: begin
				if (rx_byte == sync_second_q) begin
					phase_d = PH_ID;
				end else if (rx_byte == sync_first_q) begin
					phase_d = PH_SYNC2;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_ID:     phase_d = PH_LEN_LO;
			PH_LEN_LO: phase_d = PH_LEN_HI;
			PH_LEN_HI: begin
				phase_d = (full_len == '0) ? PH_SUM_A : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				push            = accept;
				push_data.kind  = KIND_PAYLOAD;
				push_data.pbyte = rx_byte;
				push_data.index = rcv_cnt_q;
				if (cnt_next == exp_len_q) phase_d = PH_SUM_A;
			end
			PH_SUM_A: phase_d = PH_SUM_B;
			PH_SUM_B: begin
				push           = accept;
				push_data.kind = KIND_REPORT;
				push_data.ok_a = first_match_q;
				push_data.ok_b = ok_b;
				push_data.good = first_match_q && ok_b;
				phase_d        = PH_HUNT;
			end
			default: begin
				phase_d = (rx_byte == sync_first_q) ? PH_SYNC2 : PH_HUNT;
			end
		endcase
	end

	// Preamble registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				REG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame state, advanced once per accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			held_id_q     <= '0;
			sum_a_q       <= '0;
			sum_b_q       <= '0;
			exp_len_q     <= '0;
			rcv_cnt_q     <= '0;
			first_match_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			case (phase_q)
				PH_ID: begin
					held_id_q <= rx_byte;
					sum_a_q   <= rx_byte;
					sum_b_q   <= rx_byte;
				end
				PH_LEN_LO: begin
					sum_a_q   <= sum_a_next;
					sum_b_q   <= sum_b_next;
					exp_len_q <= {{(LEN_W-BYTE_W){1'b0}}, rx_byte};
				end
				PH_LEN_HI: begin
					sum_a_q   <= sum_a_next;
					sum_b_q   <= sum_b_next;
					exp_len_q <= full_len;
					rcv_cnt_q <= '0;
				end
				PH_PAYLOAD: begin
					sum_a_q   <= sum_a_next;
					sum_b_q   <= sum_b_next;
					rcv_cnt_q <= cnt_next;
				end
				PH_SUM_A: first_match_q <= (sum_a_q == rx_byte);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/bgfp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgfp_queue: short result queue between front and back
// A small circular buffer that lets the parser keep taking bytes while
// the output side is stalled.
// ----------------------------------------------------------------------------
module bgfp_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire bgfp_pkg::result_t   push_data,
	input  wire logic                pop,
	output bgfp_pkg::result_t        pop_data,
	output bgfp_pkg::q_status_t      stat
);
	import bgfp_pkg::*;

	result_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_data   = mem_q[rd_ptr_q];

	// Entry storage; written at the tail.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/bgfp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgfp_back: output register stage
// Pulls result items from the queue into a registered output and holds
// them until the consumer takes them.
// ----------------------------------------------------------------------------
module bgfp_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bgfp_pkg::q_status_t         q_stat,
	input  wire bgfp_pkg::result_t           pop_data,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             result_kind,
	output logic [bgfp_pkg::BYTE_W-1:0]      message_id,
	output logic [bgfp_pkg::BYTE_W-1:0]      payload_byte,
	output logic [bgfp_pkg::LEN_W-1:0]       byte_index,
	output logic [bgfp_pkg::LEN_W-1:0]       frame_length,
	output logic                             first_sum_ok,
	output logic                             second_sum_ok,
	output logic                             frame_good
);
	import bgfp_pkg::*;

	logic    valid_q;
	result_t data_q;

	// Load a new item when the output register is empty or being taken.
	assign pop = !q_stat.empty && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) data_q <= pop_data;
	end

	assign out_valid     = valid_q;
	assign result_kind   = data_q.kind;
	assign message_id    = data_q.id;
	assign payload_byte  = data_q.pbyte;
	assign byte_index    = data_q.index;
	assign frame_length  = data_q.length;
	assign first_sum_ok  = data_q.ok_a;
	assign second_sum_ok = data_q.ok_b;
	assign frame_good    = data_q.good;

endmodule

`default_nettype wire

// ----- design/binary_gnss_frame_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_gnss_frame_parser: two-byte preamble frame parser
// Hunts for the preamble, reads id and length, checks the two running
// checksum bytes and reports each payload byte and the end of each frame.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    rx_byte
//   output    out        out_valid / out_ready  result_kind .. frame_good
//   config    in         cfg_we                 cfg_index, cfg_data
//
// One byte is accepted per cycle while in_ready is high; the parser state
// updates in that cycle. A result item is written into the queue when its
// byte is accepted and moves from there into the output register.
// Reset leaves the parser hunting with the default preamble values.
// A two-entry queue and the output register absorb output stalls; input
// ready drops only once the queue is full.
// ----------------------------------------------------------------------------
module binary_gnss_frame_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [bgfp_pkg::BYTE_W-1:0]    rx_byte,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                result_kind,
	output logic [bgfp_pkg::BYTE_W-1:0]         message_id,
	output logic [bgfp_pkg::BYTE_W-1:0]         payload_byte,
	output logic [bgfp_pkg::LEN_W-1:0]          byte_index,
	output logic [bgfp_pkg::LEN_W-1:0]          frame_length,
	output logic                                first_sum_ok,
	output logic                                second_sum_ok,
	output logic                                frame_good,
	input  wire logic                           cfg_we,
	input  wire logic [bgfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bgfp_pkg::BYTE_W-1:0]    cfg_data
);
	import bgfp_pkg::*;

	logic      push;
	result_t   push_data;
	logic      pop;
	result_t   pop_data;
	q_status_t q_stat;

	// Parser front.
	bgfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// Result queue.
	bgfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// Output stage.
	bgfp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.pop_data      (pop_data),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_kind   (result_kind),
		.message_id    (message_id),
		.payload_byte  (payload_byte),
		.byte_index    (byte_index),
		.frame_length  (frame_length),
		.first_sum_ok  (first_sum_ok),
		.second_sum_ok (second_sum_ok),
		.frame_good    (frame_good)
	);

endmodule

`default_nettype wire

// ----- design/bgfp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgfp_checker: port-level checks of the frame parser
// Watches the output channel of the top level and checks result item
// consistency over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bgfp_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire logic                           result_kind,
	input  wire logic [bgfp_pkg::BYTE_W-1:0]    message_id,
	input  wire logic [bgfp_pkg::BYTE_W-1:0]    payload_byte,
	input  wire logic [bgfp_pkg::LEN_W-1:0]     byte_index,
	input  wire logic [bgfp_pkg::LEN_W-1:0]     frame_length,
	input  wire logic                           first_sum_ok,
	input  wire logic                           second_sum_ok,
	input  wire logic                           frame_good
);
	import bgfp_pkg::*;

	// A stalled output item stays put.
	`BGFP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(message_id)
		&& $stable(payload_byte) && $stable(byte_index) && $stable(frame_length)
		&& $stable(result_kind), "output item changed while stalled")

	// A payload item carries no checksum flags.
	`BGFP_ASSERT(a_payload_flags, out_valid && result_kind == KIND_PAYLOAD |-> !first_sum_ok && !second_sum_ok && !frame_good, "payload item carries checksum flags")

	// A frame end is good exactly when both checksum bytes matched.
	`BGFP_ASSERT(a_good_flag, out_valid |-> frame_good == (first_sum_ok && second_sum_ok), "frame_good disagrees with the sum flags")

	// A frame end report has no payload byte and index zero.
	`BGFP_ASSERT(a_report_zero, out_valid && result_kind == KIND_REPORT |-> payload_byte == '0 && byte_index == '0, "frame end report carries payload fields")

endmodule

bind binary_gnss_frame_parser bgfp_checker u_bgfp_checker (.*);

`default_nettype wire
